// File: design/bed_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bed_pkg
// Shared types, character codes and helpers for the backslash escape decoder.
// ----------------------------------------------------------------------------
package bed_pkg;

  // parse mode codes
  localparam logic [2:0] MODE_NORMAL = 3'd0;
  localparam logic [2:0] MODE_ESC    = 3'd1;
  localparam logic [2:0] MODE_OCT    = 3'd2;
  localparam logic [2:0] MODE_HEX1   = 3'd3;
  localparam logic [2:0] MODE_HEX2   = 3'd4;
  localparam logic [2:0] MODE_DROP   = 3'd5;

  // characters
  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_BSL   = 8'h5C;
  localparam logic [7:0] CH_SQUOT = 8'h27;
  localparam logic [7:0] CH_DQUOT = 8'h22;
  localparam logic [7:0] CH_B     = 8'h62;
  localparam logic [7:0] CH_F     = 8'h66;
  localparam logic [7:0] CH_T     = 8'h74;
  localparam logic [7:0] CH_N     = 8'h6E;
  localparam logic [7:0] CH_R     = 8'h72;
  localparam logic [7:0] CH_V     = 8'h76;
  localparam logic [7:0] CH_A     = 8'h61;
  localparam logic [7:0] CH_X     = 8'h78;

  // control bytes for the simple escapes
  localparam logic [7:0] BYTE_BS  = 8'h08;
  localparam logic [7:0] BYTE_FF  = 8'h0C;
  localparam logic [7:0] BYTE_TAB = 8'h09;
  localparam logic [7:0] BYTE_LF  = 8'h0A;
  localparam logic [7:0] BYTE_CR  = 8'h0D;
  localparam logic [7:0] BYTE_VT  = 8'h0B;
  localparam logic [7:0] BYTE_BEL = 8'h07;

  localparam int unsigned FIFO_DEPTH = 4;
  localparam int unsigned PTR_W      = $clog2(FIFO_DEPTH);
  localparam int unsigned CNT_W      = $clog2(FIFO_DEPTH + 1);

  typedef struct packed {
    logic [7:0] byte_out;
    logic       has_byte;
    logic       decode_error;
    logic       end_of_string;
  } res_t;

  // results from one decoded beat, in delivery order
  typedef struct packed {
    logic [1:0] n;
    res_t       r0;
    res_t       r1;
  } push_t;

  typedef struct packed {
    logic       ok;
    logic [3:0] val;
  } hex_t;

  function automatic hex_t hex_decode(input logic [7:0] c);
    hex_t h;
    h.ok  = 1'b1;
    h.val = 4'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      h.val = c[3:0];
    end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
      h.val = c[3:0] + 4'd9;
    end else begin
      h.ok = 1'b0;
    end
    return h;
  endfunction

  function automatic logic is_octal(input logic [7:0] c);
    return (c[7:3] == 5'b00110);
  endfunction

endpackage

// File: design/backslash_escape_decoder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// backslash_escape_decoder
// Decodes a backslash-escaped character stream into bytes, one char a beat.
// ----------------------------------------------------------------------------
//  channel | direction | handshake          | payload
//  in_     | input     | in_valid/in_stall  | char_in, is_last_char
//  out_    | output    | out_valid/out_stall| byte_out, has_byte, decode_error,
//          |           |                    | end_of_string
//
// One character per cycle while in_stall is low; a beat passes the input
// register, then the result queue, before it reaches out_. A flushed octal
// escape makes two results from one character, so that character gives two
// output beats. Input is stalled while the four-entry result queue cannot take two.
// Reset (rst_n low, synchronous) empties both stages and returns to plain text.
// ----------------------------------------------------------------------------
module backslash_escape_decoder (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_char_in,
  input  logic       in_is_last_char,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_byte_out,
  output logic       out_has_byte,
  output logic       out_decode_error,
  output logic       out_end_of_string
);
  import bed_pkg::*;

  logic       in_vld_r, in_vld_nxt;
  logic [7:0] char_r;
  logic       last_r;
  logic       room2, proc, in_take;
  push_t      push;
  res_t       out_res;

  assign proc     = in_vld_r && room2;
  assign in_stall = in_vld_r && !room2;
  assign in_take  = in_valid && !in_stall;

  always_comb begin
    in_vld_nxt = in_vld_r;
    if (in_take) begin
      in_vld_nxt = 1'b1;
    end else if (proc) begin
      in_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else begin
      in_vld_r <= in_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      char_r <= in_char_in;
      last_r <= in_is_last_char;
    end
  end

  bed_decode u_decode (
    .clk          (clk),
    .rst_n        (rst_n),
    .proc         (proc),
    .char_in      (char_r),
    .is_last_char (last_r),
    .push         (push)
  );

  bed_out_fifo u_out_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .room2     (room2),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_res   (out_res)
  );

  assign out_byte_out      = out_res.byte_out;
  assign out_has_byte      = out_res.has_byte;
  assign out_decode_error  = out_res.decode_error;
  assign out_end_of_string = out_res.end_of_string;

endmodule

// File: design/bed_decode.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bed_decode
// Parse state and single-pass decode of one character into up to two results.
// ----------------------------------------------------------------------------
module bed_decode (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           proc,
  input  logic [7:0]     char_in,
  input  logic           is_last_char,
  output bed_pkg::push_t push
);
  import bed_pkg::*;

  logic [2:0] mode_r, mode_nxt, mode_mid;
  logic [7:0] acc_r, acc_nxt, acc_mid;
  logic [1:0] cnt_r, cnt_nxt, cnt_mid;

  logic       hb, fail, plain, pre_v, main_v;
  logic [7:0] b;
  res_t       pre_res, main_res;
  hex_t       hx;

  always_comb begin
    mode_mid = mode_r;
    acc_mid  = acc_r;
    cnt_mid  = cnt_r;
    hb       = 1'b0;
    b        = 8'd0;
    fail     = 1'b0;
    plain    = 1'b0;
    pre_v    = 1'b0;
    main_v   = 1'b0;
    pre_res  = '{byte_out: acc_r, has_byte: 1'b1, decode_error: 1'b0, end_of_string: 1'b0};
    main_res = '0;
    hx       = hex_decode(char_in);

    unique case (mode_r)
      MODE_DROP: begin
        // swallow the rest of a bad string
      end
      MODE_ESC: begin
        mode_mid = MODE_NORMAL;
        case (char_in)
          CH_NL: ;
          CH_BSL, CH_SQUOT, CH_DQUOT: begin
            hb = 1'b1;
            b  = char_in;
          end
          CH_B: begin hb = 1'b1; b = BYTE_BS;  end
          CH_F: begin hb = 1'b1; b = BYTE_FF;  end
          CH_T: begin hb = 1'b1; b = BYTE_TAB; end
          CH_N: begin hb = 1'b1; b = BYTE_LF;  end
          CH_R: begin hb = 1'b1; b = BYTE_CR;  end
          CH_V: begin hb = 1'b1; b = BYTE_VT;  end
          CH_A: begin hb = 1'b1; b = BYTE_BEL; end
          CH_X: mode_mid = MODE_HEX1;
          default: begin
            if (is_octal(char_in)) begin
              acc_mid  = {5'd0, char_in[2:0]};
              cnt_mid  = 2'd1;
              mode_mid = MODE_OCT;
            end else begin
              fail = 1'b1;
            end
          end
        endcase
      end
      MODE_OCT: begin
        if (is_octal(char_in)) begin
          acc_mid = {acc_r[4:0], char_in[2:0]};
          cnt_mid = cnt_r + 2'd1;
          if (cnt_mid == 2'd3) begin
            hb       = 1'b1;
            b        = acc_mid;
            mode_mid = MODE_NORMAL;
            cnt_mid  = 2'd0;
          end
        end else begin
          // flush the pending octal byte ahead of this character
          pre_v    = 1'b1;
          mode_mid = MODE_NORMAL;
          cnt_mid  = 2'd0;
          plain    = 1'b1;
        end
      end
      MODE_HEX1: begin
        if (hx.ok) begin
          acc_mid  = {4'd0, hx.val};
          mode_mid = MODE_HEX2;
        end else begin
          fail = 1'b1;
        end
      end
      MODE_HEX2: begin
        if (hx.ok) begin
          hb       = 1'b1;
          b        = {acc_r[3:0], hx.val};
          mode_mid = MODE_NORMAL;
        end else begin
          fail = 1'b1;
        end
      end
      default: begin
        mode_mid = MODE_NORMAL;
        plain    = 1'b1;
      end
    endcase

    if (plain) begin
      if (char_in == CH_BSL) begin
        mode_mid = MODE_ESC;
      end else begin
        hb = 1'b1;
        b  = char_in;
      end
    end

    // end of string with an escape still open
    if (mode_r != MODE_DROP && !fail && is_last_char) begin
      if (mode_mid == MODE_OCT) begin
        hb = 1'b1;
        b  = acc_mid;
      end else if (mode_mid == MODE_ESC || mode_mid == MODE_HEX1 ||
                   mode_mid == MODE_HEX2) begin
        fail = 1'b1;
      end
    end

    mode_nxt = mode_mid;
    acc_nxt  = acc_mid;
    cnt_nxt  = cnt_mid;

    if (mode_r == MODE_DROP) begin
      if (is_last_char) begin
        main_v   = 1'b1;
        main_res = '{byte_out: 8'd0, has_byte: 1'b0, decode_error: 1'b1,
                     end_of_string: 1'b1};
      end
    end else if (fail) begin
      main_v   = 1'b1;
      main_res = '{byte_out: 8'd0, has_byte: 1'b0, decode_error: 1'b1,
                   end_of_string: is_last_char};
      if (!is_last_char) begin
        mode_nxt = MODE_DROP;
      end
    end else if (is_last_char) begin
      main_v   = 1'b1;
      main_res = '{byte_out: hb ? b : 8'd0, has_byte: hb, decode_error: 1'b0,
                   end_of_string: 1'b1};
    end else if (hb) begin
      main_v   = 1'b1;
      main_res = '{byte_out: b, has_byte: 1'b1, decode_error: 1'b0, end_of_string: 1'b0};
    end

    if (is_last_char) begin
      mode_nxt = MODE_NORMAL;
      acc_nxt  = 8'd0;
      cnt_nxt  = 2'd0;
    end

    if (pre_v) begin
      push.n  = main_v ? 2'd2 : 2'd1;
      push.r0 = pre_res;
      push.r1 = main_res;
    end else begin
      push.n  = main_v ? 2'd1 : 2'd0;
      push.r0 = main_res;
      push.r1 = main_res;
    end
    if (!proc) begin
      push.n = 2'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_NORMAL;
      acc_r  <= 8'd0;
      cnt_r  <= 2'd0;
    end else if (proc) begin
      mode_r <= mode_nxt;
      acc_r  <= acc_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

endmodule

// File: design/bed_out_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bed_out_fifo
// Small result queue: takes up to two results a cycle, hands out one while out_stall is low.
// ----------------------------------------------------------------------------
module bed_out_fifo (
  input  logic           clk,
  input  logic           rst_n,
  input  bed_pkg::push_t push,
  output logic           room2,
  output logic           out_valid,
  input  logic           out_stall,
  output bed_pkg::res_t  out_res
);
  import bed_pkg::*;

  res_t             mem_r [FIFO_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt, wr_ptr_p1;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             pop;

  assign room2     = (cnt_r <= CNT_W'(FIFO_DEPTH - 2));
  assign out_valid = (cnt_r != '0);
  assign out_res   = mem_r[rd_ptr_r];
  assign pop       = out_valid && !out_stall;
  assign wr_ptr_p1 = wr_ptr_r + PTR_W'(1);

  always_comb begin
    wr_ptr_nxt = wr_ptr_r + PTR_W'(push.n);
    rd_ptr_nxt = rd_ptr_r + PTR_W'(pop);
    cnt_nxt    = cnt_r + CNT_W'(push.n) - CNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (push.n != 2'd0) begin
      mem_r[wr_ptr_r] <= push.r0;
    end
    if (push.n == 2'd2) begin
      mem_r[wr_ptr_p1] <= push.r1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule

// File: design/bed_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bed_checker
// Port-level checks on the escape decoder's result channel.
// ----------------------------------------------------------------------------
module bed_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_stall,
  input logic [7:0] out_byte_out,
  input logic       out_has_byte,
  input logic       out_decode_error,
  input logic       out_end_of_string
);

  // a stalled beat stays up
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result beat dropped while stalled");

  a_no_byte_err: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_has_byte && out_decode_error))
    else $error("error result carries a byte");

  // a result with neither byte nor error can only close a string
  a_empty_is_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_has_byte && !out_decode_error |-> out_end_of_string)
    else $error("empty result that is not end of string");

  a_zero_byte: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_has_byte |-> out_byte_out == 8'd0)
    else $error("byte_out nonzero without has_byte");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

endmodule

bind backslash_escape_decoder bed_checker u_bed_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .out_valid         (out_valid),
  .out_stall         (out_stall),
  .out_byte_out      (out_byte_out),
  .out_has_byte      (out_has_byte),
  .out_decode_error  (out_decode_error),
  .out_end_of_string (out_end_of_string)
);

// File: tb/backslash_escape_decoder_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// backslash_escape_decoder_tb
// Self-checking bench for the escape decoder: directed strings for the corner
// cases, then random escaped strings. A scoreboard predicts the decoded beats
// and checks each output beat in order, with random idle and stall on both
// channels.
// ----------------------------------------------------------------------------
module backslash_escape_decoder_tb;
  import bed_pkg::*;

  localparam int TARGET_CHARS = 950;
  localparam int CYCLE_LIMIT  = 500000;
  localparam int DRAIN_CYCLES = 16;

  // Predicts decoded beats from accepted characters and checks output beats.
  class decode_board;
    logic [2:0] mode;
    logic [7:0] accum;
    logic [1:0] digits;
    res_t       decoded_q[$];
    int         errors;

    function new();
      errors = 0;
      clear();
    endfunction

    function void clear();
      mode   = MODE_NORMAL;
      accum  = 8'd0;
      digits = 2'd0;
    endfunction

    static function logic is_oct(logic [7:0] c);
      return (c >= "0" && c <= "7");
    endfunction

    // {valid, nibble}
    static function logic [4:0] hex_nibble(logic [7:0] c);
      logic [7:0] d;
      if (c >= "0" && c <= "9") begin
        d = c - "0";
      end else if (c >= "a" && c <= "f") begin
        d = c - "a" + 8'd10;
      end else if (c >= "A" && c <= "F") begin
        d = c - "A" + 8'd10;
      end else begin
        return 5'd0;
      end
      return {1'b1, d[3:0]};
    endfunction

    function void add(logic [7:0] b, logic hb, logic err, logic eos);
      res_t r;
      r.byte_out      = b;
      r.has_byte      = hb;
      r.decode_error  = err;
      r.end_of_string = eos;
      decoded_q = {decoded_q, r};
    endfunction

    function int pending();
      return decoded_q.size();
    endfunction

    function void note_char(logic [7:0] c, logic last);
      logic       hb, fail, plain;
      logic [7:0] b;
      logic [4:0] hv;
      hb    = 1'b0;
      fail  = 1'b0;
      plain = 1'b0;
      b     = 8'd0;
      case (mode)
        MODE_DROP: begin
          if (last) begin
            add(8'd0, 1'b0, 1'b1, 1'b1);
            clear();
          end
          return;
        end
        MODE_ESC: begin
          mode = MODE_NORMAL;
          case (c)
            CH_NL: ;
            CH_BSL, CH_SQUOT, CH_DQUOT: begin hb = 1'b1; b = c;        end
            CH_B:                       begin hb = 1'b1; b = BYTE_BS;  end
            CH_F:                       begin hb = 1'b1; b = BYTE_FF;  end
            CH_T:                       begin hb = 1'b1; b = BYTE_TAB; end
            CH_N:                       begin hb = 1'b1; b = BYTE_LF;  end
            CH_R:                       begin hb = 1'b1; b = BYTE_CR;  end
            CH_V:                       begin hb = 1'b1; b = BYTE_VT;  end
            CH_A:                       begin hb = 1'b1; b = BYTE_BEL; end
            CH_X: mode = MODE_HEX1;
            default: begin
              if (is_oct(c)) begin
                accum  = c - "0";
                digits = 2'd1;
                mode   = MODE_OCT;
              end else begin
                fail = 1'b1;
              end
            end
          endcase
        end
        MODE_OCT: begin
          if (is_oct(c)) begin
            accum  = (accum << 3) + (c - "0");
            digits = digits + 2'd1;
            if (digits == 2'd3) begin
              hb     = 1'b1;
              b      = accum;
              mode   = MODE_NORMAL;
              digits = 2'd0;
            end
          end else begin
            // octal ended early: its byte goes out as a beat of its own
            add(accum, 1'b1, 1'b0, 1'b0);
            mode   = MODE_NORMAL;
            digits = 2'd0;
            plain  = 1'b1;
          end
        end
        MODE_HEX1: begin
          hv = hex_nibble(c);
          if (!hv[4]) begin
            fail = 1'b1;
          end else begin
            accum = {4'd0, hv[3:0]};
            mode  = MODE_HEX2;
          end
        end
        MODE_HEX2: begin
          hv = hex_nibble(c);
          if (!hv[4]) begin
            fail = 1'b1;
          end else begin
            hb   = 1'b1;
            b    = {accum[3:0], hv[3:0]};
            mode = MODE_NORMAL;
          end
        end
        default: begin
          mode  = MODE_NORMAL;
          plain = 1'b1;
        end
      endcase

      if (plain) begin
        if (c == CH_BSL) begin
          mode = MODE_ESC;
        end else begin
          hb = 1'b1;
          b  = c;
        end
      end

      if (!fail && last) begin
        if (mode == MODE_OCT) begin
          hb = 1'b1;
          b  = accum;
        end else if (mode == MODE_ESC || mode == MODE_HEX1 || mode == MODE_HEX2) begin
          fail = 1'b1;
        end
      end

      if (fail) begin
        add(8'd0, 1'b0, 1'b1, last);
        if (last) clear();
        else mode = MODE_DROP;
      end else if (last) begin
        add(hb ? b : 8'd0, hb, 1'b0, 1'b1);
        clear();
      end else if (hb) begin
        add(b, 1'b1, 1'b0, 1'b0);
      end
    endfunction

    function void report(string field, logic [7:0] want, logic [7:0] got);
      $display("%0t: %s mismatch, expected %h, actual %h", $time, field, want, got);
      errors++;
    endfunction

    function void check_result(res_t got);
      res_t want;
      if (decoded_q.size() == 0) begin
        $display("%0t: unexpected beat, expected none, actual %h/%b/%b/%b", $time,
                 got.byte_out, got.has_byte, got.decode_error, got.end_of_string);
        errors++;
        return;
      end
      want = decoded_q.pop_front();
      if (got.byte_out !== want.byte_out)
        report("byte_out", want.byte_out, got.byte_out);
      if (got.has_byte !== want.has_byte)
        report("has_byte", {7'd0, want.has_byte}, {7'd0, got.has_byte});
      if (got.decode_error !== want.decode_error)
        report("decode_error", {7'd0, want.decode_error}, {7'd0, got.decode_error});
      if (got.end_of_string !== want.end_of_string)
        report("end_of_string", {7'd0, want.end_of_string}, {7'd0, got.end_of_string});
    endfunction
  endclass

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [7:0] in_char_in = 8'd0;
  logic       in_is_last_char = 1'b0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [7:0] out_byte_out;
  logic       out_has_byte;
  logic       out_decode_error;
  logic       out_end_of_string;

  decode_board sb;
  logic [7:0]  text_q[$];
  int          chars_sent = 0;
  int          cycles = 0;
  int          stall_left = 0;
  bit          in_calm = 1'b0;
  bit          out_calm = 1'b0;
  logic [7:0]  esc_chars[10] = '{CH_BSL, CH_SQUOT, CH_DQUOT, CH_B, CH_F,
                                 CH_T, CH_N, CH_R, CH_V, CH_A};

  backslash_escape_decoder dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_char_in       (in_char_in),
    .in_is_last_char  (in_is_last_char),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_byte_out     (out_byte_out),
    .out_has_byte     (out_has_byte),
    .out_decode_error (out_decode_error),
    .out_end_of_string(out_end_of_string)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 85) return $urandom_range(1, 2);
    if (r < 97) return $urandom_range(3, 8);
    return $urandom_range(12, 40);
  endfunction

  // output side: check accepted beats, then pick the next stall
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      sb.check_result(res_t'({out_byte_out, out_has_byte, out_decode_error,
                              out_end_of_string}));
    if (cycles % 300 == 0) out_calm = ($urandom_range(0, 3) == 0);
    if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left--;
    end else begin
      out_stall <= 1'b0;
      stall_left = out_calm ? 0 : pick_gap();
    end
  end

  task automatic send_char(input logic [7:0] c, input logic last);
    int gap;
    gap = in_calm ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_char_in      <= c;
    in_is_last_char <= last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_char(c, last);
    chars_sent++;
  endtask

  task automatic send_text();
    for (int i = 0; i < text_q.size(); i++)
      send_char(text_q[i], i == text_q.size() - 1);
    text_q = {};
  endtask

  task automatic queue_char(input logic [7:0] c);
    text_q = {text_q, c};
  endtask

  task automatic add_text(input string s);
    for (int i = 0; i < s.len(); i++) queue_char(s[i]);
  endtask

  // sender holds off until the scoreboard is empty
  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  function automatic logic [7:0] hex_char(input int n);
    if (n < 10) return 8'("0" + n);
    return 8'(($urandom_range(0, 1) ? "a" : "A") + n - 10);
  endfunction

  function automatic logic [7:0] any_plain();
    logic [7:0] c;
    c = $urandom_range(0, 1) ? 8'($urandom_range(0, 255)) : 8'($urandom_range(32, 126));
    return (c == CH_BSL) ? 8'h5A : c;
  endfunction

  task automatic add_token();
    int r, n;
    r = $urandom_range(0, 99);
    if (r < 30) begin
      queue_char(any_plain());
    end else if (r < 50) begin
      queue_char(CH_BSL);
      queue_char(esc_chars[$urandom_range(0, 9)]);
    end else if (r < 63) begin
      queue_char(CH_BSL);
      n = $urandom_range(1, 3);
      repeat (n) queue_char(8'("0" + $urandom_range(0, 7)));
    end else if (r < 78) begin
      queue_char(CH_BSL);
      queue_char(CH_X);
      queue_char(hex_char($urandom_range(0, 15)));
      queue_char(hex_char($urandom_range(0, 15)));
    end else if (r < 83) begin
      queue_char(CH_BSL);
      queue_char(CH_NL);
    end else if (r < 90) begin
      // backslash plus any byte: mostly unknown escapes
      queue_char(CH_BSL);
      queue_char(8'($urandom_range(0, 255)));
    end else if (r < 95) begin
      queue_char(CH_BSL);
      queue_char(CH_X);
      if ($urandom_range(0, 1)) queue_char(hex_char($urandom_range(0, 15)));
      queue_char(8'($urandom_range(0, 255)));
    end else begin
      queue_char(CH_BSL);
    end
  endtask

  initial begin
    int ntok;
    sb = new();
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: extreme bytes, octal flush, wrap, pending octal at end,
    // hex of both cases, escaped newline at end, errors and dropped chars
    queue_char(8'h00);
    queue_char(8'hFF);
    send_text();
    add_text("\\12A");   send_text();
    add_text("\\777");   send_text();
    add_text("\\5");     send_text();
    add_text("\\xaF\\\n"); send_text();
    add_text("\\qz");    send_text();
    add_text("\\x4Q");   send_text();
    add_text("\\x4");    send_text();
    add_text("\\");      send_text();
    drain();

    while (chars_sent < TARGET_CHARS) begin
      in_calm = ($urandom_range(0, 5) == 0);
      if ($urandom_range(0, 9) == 0) begin
        queue_char(8'($urandom_range(0, 255)));
      end else begin
        ntok = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 20) : $urandom_range(1, 6);
        repeat (ntok) add_token();
      end
      send_text();
      if ($urandom_range(0, 39) == 0) drain();
    end

    drain();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule
